### src/integer_literal_parser_defines.svh
// Assertion macros for the integer literal parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define ILP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ILP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ILP_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define ILP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### src/ilp_pkg.sv
// Shared types, constants and the digit decoder of the integer literal parser.
// No dependencies.
package ilp_pkg;

  // Radix mode register codes
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } ilp_radix_t;

  // Configuration register index (word address)
  localparam logic REG_RADIX_MODE = 1'b0;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  // Largest negative magnitude, 2^63
  localparam logic [63:0] LIM63 = 64'h8000_0000_0000_0000;

  // Input request
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ilp_in_t;

  // Result
  typedef struct packed {
    logic              status;
    logic signed [63:0] value;
    logic              overflowed;
  } ilp_out_t;

  // Command from the classifier to the accumulator
  typedef struct packed {
    logic       digit_en;
    logic [3:0] digit;
    logic       last;
    logic       bad;
    logic       neg;
  } ilp_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } ilp_digit_t;

  // Decode one character as a digit of the selected radix
  function automatic ilp_digit_t digit_of(input logic [1:0] mode, input logic [7:0] c);
    ilp_digit_t d;
    d.valid = 1'b0;
    d.val   = 4'd0;
    case (mode)
      RADIX_BIN: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          d.valid = 1'b1;
          d.val   = 4'(c - CH_ZERO);
        end
      end
      RADIX_DEC: begin
        if (c inside {[CH_ZERO:CH_NINE]}) begin
          d.valid = 1'b1;
          d.val   = 4'(c - CH_ZERO);
        end
      end
      RADIX_HEX: begin
        if (c inside {[CH_ZERO:CH_NINE]}) begin
          d.valid = 1'b1;
          d.val   = 4'(c - CH_ZERO);
        end else if (c inside {[CH_LA:CH_LF]}) begin
          d.valid = 1'b1;
          d.val   = 4'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_UA:CH_UF]}) begin
          d.valid = 1'b1;
          d.val   = 4'(c - CH_UA + 8'd10);
        end
      end
      default: begin
        d.valid = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

### src/integer_literal_parser.sv
// Top level of the integer literal parser: configuration register, classifier,
// command queue, accumulator and result queue. Depends on ilp_pkg and the
// ilp_front, ilp_back and ilp_fifo modules.
//
// The parser takes one character per clock cycle while the command queue is not
// full, with no gaps between literals, and gives one result per literal after its
// final character. A character goes through the classifier in the cycle it is
// accepted, is registered in the command queue, and is folded into the magnitude by
// the accumulator (one shift-add per digit); a final character then passes through
// the accumulator's finished-result registers into the result queue, and the result
// becomes visible once the result queue holds it. The accumulator's single 64-bit
// multiply-by-radix-and-add sets the cycle time. The command and result queues
// decouple input and output stalls; their depths are set by CMD_QUEUE_DEPTH and
// RESULT_QUEUE_DEPTH. Register 0 at byte address 0 holds radix_mode (0 binary, 1
// decimal, 2 hex; reset 1); write it only while no literal is in flight.
module integer_literal_parser
  import ilp_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH    = 2,
  parameter int RESULT_QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input queue side
  input  logic        push,
  input  ilp_in_t     in_data,
  output logic        full,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output ilp_out_t    out_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] radix_mode_r;
  logic       cfg_wr;
  logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
  ilp_cmd_t   cmd_wdata, cmd_rdata;
  logic       res_push, res_full;
  ilp_out_t   res_wdata;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r <= RADIX_DEC;
    end else if (cfg_wr) begin
      radix_mode_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RADIX_MODE) ? {30'b0, radix_mode_r} : 32'b0;

  ilp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix_mode (radix_mode_r),
    .in_push    (push),
    .in_data    (in_data),
    .in_full    (full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wdata),
    .cmd_full   (cmd_full)
  );

  ilp_fifo #(
    .WIDTH ($bits(ilp_cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  ilp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix_mode (radix_mode_r),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_rdata),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res_data   (res_wdata),
    .res_full   (res_full)
  );

  ilp_fifo #(
    .WIDTH ($bits(ilp_out_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

### src/ilp_fifo.sv
// Small register-based queue used between the parser stages and at the output.
// Depends on nothing but the payload width given by the instantiating module.
module ilp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/ilp_front.sv
// Classifier: tracks sign, prefix and validity of the literal and emits one
// command per character. Depends on ilp_pkg.
`include "integer_literal_parser_defines.svh"

module ilp_front
  import ilp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] radix_mode,
  input  logic       in_push,
  input  ilp_in_t    in_data,
  output logic       in_full,
  output logic       cmd_push,
  output ilp_cmd_t   cmd_data,
  input  logic       cmd_full
);

  typedef enum logic [2:0] {
    POS_START = 3'b001,
    POS_SIGN  = 3'b010,
    POS_BODY  = 3'b100
  } ilp_pos_t;

  ilp_pos_t   pos_r, pos_nxt;
  logic       neg_r, neg_nxt;
  logic       seen_r, seen_nxt;
  logic       lz_r, lz_nxt;
  logic       bad_r, bad_nxt;
  logic       accept;
  logic [7:0] c;
  logic       is_sign, is_prefix, prefix_mode;
  ilp_digit_t dig;

  assign in_full     = cmd_full;
  assign accept      = in_push && !cmd_full;
  assign cmd_push    = accept;
  assign c           = in_data.char_code;
  assign dig         = digit_of(radix_mode, c);
  assign prefix_mode = (radix_mode == RADIX_BIN) || (radix_mode == RADIX_HEX);
  assign is_sign     = (pos_r == POS_START) && (c == CH_MINUS || c == CH_PLUS);
  assign is_prefix   = lz_r && (((radix_mode == RADIX_BIN) && (c == CH_LB)) ||
                                ((radix_mode == RADIX_HEX) && (c == CH_LX)));

  // Classify the character and update the literal state
  always_comb begin
    pos_nxt           = pos_r;
    neg_nxt           = neg_r;
    seen_nxt          = seen_r;
    lz_nxt            = lz_r;
    bad_nxt           = bad_r;
    cmd_data.digit_en = 1'b0;
    cmd_data.digit    = dig.val;
    if (!bad_r) begin
      if (is_sign) begin
        neg_nxt = (c == CH_MINUS);
        pos_nxt = POS_SIGN;
      end else if (is_prefix) begin
        seen_nxt = 1'b0;
        lz_nxt   = 1'b0;
        pos_nxt  = POS_BODY;
      end else begin
        lz_nxt  = (pos_r != POS_BODY) && (c == CH_ZERO) && prefix_mode;
        pos_nxt = POS_BODY;
        if (dig.valid) begin
          seen_nxt          = 1'b1;
          cmd_data.digit_en = 1'b1;
        end else if (c != CH_UNDER) begin
          bad_nxt = 1'b1;
        end
      end
    end
    cmd_data.last = in_data.last_char;
    cmd_data.bad  = bad_nxt || !seen_nxt;
    cmd_data.neg  = neg_nxt;
  end

  // Hold state between characters; clear after the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_START;
      neg_r  <= 1'b0;
      seen_r <= 1'b0;
      lz_r   <= 1'b0;
      bad_r  <= 1'b0;
    end else if (accept) begin
      if (in_data.last_char) begin
        pos_r  <= POS_START;
        neg_r  <= 1'b0;
        seen_r <= 1'b0;
        lz_r   <= 1'b0;
        bad_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        neg_r  <= neg_nxt;
        seen_r <= seen_nxt;
        lz_r   <= lz_nxt;
        bad_r  <= bad_nxt;
      end
    end
  end

  `ILP_ASSERT_NEVER(a_no_digit_after_bad, clk, rst_n, cmd_push && bad_r && cmd_data.digit_en, "digit command after malformed char")
  `ILP_ASSERT(a_prefix_opens_body, clk, rst_n, (accept && !in_data.last_char && !bad_r && is_prefix) |=> (pos_r == POS_BODY && !seen_r), "prefix did not open body")

endmodule

### src/ilp_back.sv
// Accumulator: folds digits into the 64-bit magnitude, tracks overflow and
// forms the signed result. Depends on ilp_pkg.
`include "integer_literal_parser_defines.svh"

module ilp_back
  import ilp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] radix_mode,
  input  logic       cmd_empty,
  input  ilp_cmd_t   cmd_data,
  output logic       cmd_pop,
  output logic       res_push,
  output ilp_out_t   res_data,
  input  logic       res_full
);

  logic [63:0] mag_r, mag_nxt;
  logic        ovf_r, ovf_nxt;
  logic        fin_valid_r;
  logic        fin_bad_r;
  logic        fin_neg_r;
  logic        fin_ovf_r;
  logic [63:0] fin_mag_r;
  logic        fin_ready, fire;
  logic [67:0] mag_ext, prod, sum;

  assign fin_ready = !fin_valid_r || !res_full;
  assign fire      = !cmd_empty && (!cmd_data.last || fin_ready);
  assign cmd_pop   = fire;
  assign res_push  = fin_valid_r && !res_full;

  // Multiply by the radix with shifts and add the digit
  assign mag_ext = {4'b0, mag_r};
  always_comb begin
    case (radix_mode)
      RADIX_BIN: prod = mag_ext << 1;
      RADIX_DEC: prod = (mag_ext << 3) + (mag_ext << 1);
      default:   prod = mag_ext << 4;
    endcase
    sum = prod + {64'b0, cmd_data.digit};
    if (cmd_data.digit_en) begin
      mag_nxt = sum[63:0];
      ovf_nxt = ovf_r || (sum > {4'b0, LIM63});
    end else begin
      mag_nxt = mag_r;
      ovf_nxt = ovf_r;
    end
  end

  // Advance the accumulator; clear at the end of a literal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      ovf_r <= 1'b0;
    end else if (fire) begin
      if (cmd_data.last) begin
        mag_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        mag_r <= mag_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // Hold the finished literal until the output queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fire && cmd_data.last) begin
      fin_valid_r <= 1'b1;
    end else if (res_push) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd_data.last) begin
      fin_bad_r <= cmd_data.bad;
      fin_neg_r <= cmd_data.neg;
      fin_mag_r <= mag_nxt;
      fin_ovf_r <= ovf_nxt || (!cmd_data.neg && (mag_nxt == LIM63));
    end
  end

  // Apply the sign; a malformed literal gives a zero value and no overflow flag
  always_comb begin
    res_data.status = fin_bad_r;
    if (fin_bad_r) begin
      res_data.value      = '0;
      res_data.overflowed = 1'b0;
    end else begin
      res_data.value      = fin_neg_r ? -fin_mag_r : fin_mag_r;
      res_data.overflowed = fin_ovf_r;
    end
  end

  `ILP_ASSERT(a_fin_holds, clk, rst_n, (fin_valid_r && res_full) |=> (fin_valid_r && $stable(fin_mag_r) && $stable(fin_bad_r)), "finished result changed while stalled")
  `ILP_ASSERT(a_acc_cleared, clk, rst_n, (fire && cmd_data.last) |=> (mag_r == '0 && !ovf_r), "accumulator not cleared after literal")

endmodule
